[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the clocked concurrent assertions used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[sv/lbbt_pkg.sv]
// ----------------------------------------------------------------------------
// lbbt_pkg
// Types, widths and codes shared by the label bounding box table.
// ----------------------------------------------------------------------------
package lbbt_pkg;

   localparam int MAX_LABELS_DEF = 4096;
   localparam int COORD_BITS_DEF = 16;

   localparam int OP_W        = 2;
   localparam int LABEL_W     = 32;
   localparam int STATUS_W    = 3;
   localparam int MIN_W       = 32;
   localparam int MAX_W       = 16;
   localparam int SIZE_W      = 16;
   localparam int LCOUNT_W    = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SIZE_W-1:0]   SIZE_RESET   = SIZE_W'(1);
   localparam logic [LCOUNT_W-1:0] LCOUNT_RESET = LCOUNT_W'(4096);

   typedef enum logic [OP_W-1:0] {
      OP_VOXEL = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_BACKGROUND = 3'd1,
      STAT_INVALID    = 3'd2,
      STAT_IGNORED    = 3'd3,
      STAT_BAD_READ   = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_SIZE_X      = 2'd0,
      CFG_SIZE_Y      = 2'd1,
      CFG_SIZE_Z      = 2'd2,
      CFG_LABEL_COUNT = 2'd3
   } cfg_index_type;

   typedef enum logic {
      ST_SWEEP = 1'b0,
      ST_RUN   = 1'b1
   } state_type;

endpackage

[sv/lbbt_ram.sv]
// ----------------------------------------------------------------------------
// lbbt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbbt_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 97
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // A read at the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/label_bounding_box_table.sv]
// ----------------------------------------------------------------------------
// label_bounding_box_table
// Per-label 3D bounding boxes over a raster-ordered stream of voxel labels.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the result side keeps up and no
// clear or sweep runs; a waiting result sits in the output register and one
// more request is still taken. The bounds of all labels live in one RAM with
// one write and one read port: a request reads its entry on acceptance and
// writes it back as it leaves the execute stage; a request that reads the
// entry being written gets the new value forwarded. After reset and after
// every clear request the block sweeps all MAX_LABELS RAM entries, one entry a
// cycle, and holds req_stall high meanwhile. Configuration writes are taken
// at any time (csr_ready is always high) but must only be made while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module label_bounding_box_table
   import lbbt_pkg::*;
#(
   parameter int MAX_LABELS = MAX_LABELS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_W-1:0]        req_op,
   input  logic signed [LABEL_W-1:0] req_label,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [MIN_W-1:0]       rsp_min_x,
   output logic [MIN_W-1:0]       rsp_min_y,
   output logic [MIN_W-1:0]       rsp_min_z,
   output logic [MAX_W-1:0]       rsp_max_x,
   output logic [MAX_W-1:0]       rsp_max_y,
   output logic [MAX_W-1:0]       rsp_max_z,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W  = $clog2(MAX_LABELS);
   localparam int CB     = COORD_BITS;
   localparam int WORD_W = 1 + 6 * COORD_BITS;
   localparam int CMP_W  = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LABELS - 1);

   // Configuration registers.
   logic [SIZE_W-1:0]   size_x_ff, size_y_ff, size_z_ff;
   logic [LCOUNT_W-1:0] label_count_ff;

   // Scan state.
   logic [CB-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [CB-1:0] pos_x_in, pos_y_in, pos_z_in;
   logic          done_ff, done_in;
   logic          error_ff, error_in;

   // Sweep sequencer.
   state_type      state_ff, state_in;
   logic [IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic           run_active;
   logic           sweep_active;

   // Execute stage.
   logic               s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]    s1_op_ff;
   logic [LABEL_W-1:0] s1_label_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0]  fwd_data_ff;

   // Output register.
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [MIN_W-1:0] rsp_min_ff [3];
   logic [MAX_W-1:0] rsp_max_ff [3];

   // RAM ports.
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;

   logic accept;
   logic out_free;
   logic s1_fire;

   // Execute stage decode and results.
   logic [WORD_W-1:0] ent;
   logic              ent_valid;
   logic [CB-1:0]     ent_min [3];
   logic [CB-1:0]     ent_max [3];
   logic [CB-1:0]     cur [3];
   logic [CB-1:0]     new_min [3];
   logic [CB-1:0]     new_max [3];
   logic [WORD_W-1:0] new_word;
   logic              lab_neg, lab_zero, lab_in_range;
   status_type        res_status;
   logic [MIN_W-1:0]  res_min [3];
   logic [MAX_W-1:0]  res_max [3];
   logic              do_adv, do_write, do_clear, set_err;

   // Position step.
   logic [CMP_W-1:0] x_inc, y_inc, z_inc;
   logic             x_wrap, y_wrap, z_wrap;
   logic [CB-1:0]    adv_x, adv_y, adv_z;
   logic             adv_done;

   lbbt_ram #(
      .DEPTH (MAX_LABELS),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ------------------------------------------------------------------------
   // Sweep sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (s1_fire && (s1_op_ff == OP_CLEAR)) begin
               state_in = ST_SWEEP;
            end
         end
      endcase
   end

   always_comb begin
      run_active   = 1'b0;
      sweep_active = 1'b0;
      unique case (state_ff)
         ST_SWEEP: sweep_active = 1'b1;
         ST_RUN:   run_active   = 1'b1;
      endcase
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (sweep_active) begin
         clr_cnt_in = (clr_cnt_ff == LAST_IDX) ? '0 : clr_cnt_ff + IDX_W'(1);
      end
   end

   // ------------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_fire  = s1_valid_ff && out_free;

   // A clear request must finish before anything reads the table again.
   assign req_stall = !(run_active && !(s1_valid_ff && (s1_op_ff == OP_CLEAR)) &&
                        (!s1_valid_ff || out_free));
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign mem_rd_en   = accept;
   assign mem_rd_addr = req_label[IDX_W-1:0];
   assign fwd_hit_in  = accept ? (mem_wr_en && (mem_wr_addr == mem_rd_addr)) : fwd_hit_ff;

   // ------------------------------------------------------------------------
   // Position step
   // ------------------------------------------------------------------------
   always_comb begin
      x_inc  = CMP_W'(pos_x_ff) + CMP_W'(1);
      y_inc  = CMP_W'(pos_y_ff) + CMP_W'(1);
      z_inc  = CMP_W'(pos_z_ff) + CMP_W'(1);
      x_wrap = !(x_inc < CMP_W'(size_x_ff));
      y_wrap = !(y_inc < CMP_W'(size_y_ff));
      z_wrap = !(z_inc < CMP_W'(size_z_ff));
      adv_x  = x_wrap ? '0 : x_inc[CB-1:0];
      adv_y  = pos_y_ff;
      adv_z  = pos_z_ff;
      adv_done = 1'b0;
      if (x_wrap) begin
         adv_y = y_wrap ? '0 : y_inc[CB-1:0];
         if (y_wrap) begin
            adv_z = z_wrap ? '0 : z_inc[CB-1:0];
            adv_done = z_wrap;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Execute stage: read or read-modify-write of one table entry
   // ------------------------------------------------------------------------
   always_comb begin
      ent       = fwd_hit_ff ? fwd_data_ff : mem_rd_data;
      ent_valid = ent[WORD_W-1];
      cur[0]    = pos_x_ff;
      cur[1]    = pos_y_ff;
      cur[2]    = pos_z_ff;
      for (int k = 0; k < 3; k++) begin
         ent_max[k] = ent[k*CB +: CB];
         ent_min[k] = ent[(3+k)*CB +: CB];
         if (ent_valid) begin
            new_min[k] = (cur[k] < ent_min[k]) ? cur[k] : ent_min[k];
            new_max[k] = (cur[k] > ent_max[k]) ? cur[k] : ent_max[k];
         end else begin
            new_min[k] = cur[k];
            new_max[k] = cur[k];
         end
      end
      new_word[WORD_W-1] = 1'b1;
      for (int k = 0; k < 3; k++) begin
         new_word[k*CB +: CB]     = new_max[k];
         new_word[(3+k)*CB +: CB] = new_min[k];
      end
   end

   always_comb begin
      lab_neg      = s1_label_ff[LABEL_W-1];
      lab_zero     = (s1_label_ff == '0);
      lab_in_range = !lab_neg && (s1_label_ff < LABEL_W'(label_count_ff)) &&
                     (s1_label_ff < LABEL_W'(MAX_LABELS));
      res_status = STAT_OK;
      do_adv     = 1'b0;
      do_write   = 1'b0;
      do_clear   = 1'b0;
      set_err    = 1'b0;
      for (int k = 0; k < 3; k++) begin
         res_min[k] = '0;
         res_max[k] = '0;
      end
      unique case (s1_op_ff)
         OP_VOXEL: begin
            if (error_ff || done_ff) begin
               res_status = STAT_IGNORED;
            end else if (lab_zero) begin
               res_status = STAT_BACKGROUND;
               do_adv     = 1'b1;
            end else if (!lab_in_range) begin
               res_status = STAT_INVALID;
               set_err    = 1'b1;
            end else begin
               do_write = 1'b1;
               do_adv   = 1'b1;
            end
         end
         OP_READ: begin
            if (lab_neg || (!lab_zero && !lab_in_range)) begin
               res_status = STAT_BAD_READ;
            end else if (lab_zero || !ent_valid) begin
               for (int k = 0; k < 3; k++) begin
                  res_min[k] = '1;
               end
            end else begin
               for (int k = 0; k < 3; k++) begin
                  res_min[k] = MIN_W'(ent_min[k]);
                  res_max[k] = MAX_W'(ent_max[k]);
               end
            end
         end
         OP_CLEAR: begin
            do_clear = 1'b1;
         end
         default: begin
            res_status = STAT_IGNORED;
         end
      endcase
   end

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      done_in  = done_ff;
      error_in = error_ff;
      if (s1_fire) begin
         if (do_clear) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
            done_in  = 1'b0;
            error_in = 1'b0;
         end else if (do_adv) begin
            pos_x_in = adv_x;
            pos_y_in = adv_y;
            pos_z_in = adv_z;
            done_in  = adv_done;
         end else if (set_err) begin
            error_in = 1'b1;
         end
      end
   end

   // The sweep writes a zero word, which clears the entry's valid bit.
   always_comb begin
      if (sweep_active) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = s1_fire && do_write;
         mem_wr_addr = s1_label_ff[IDX_W-1:0];
         mem_wr_data = new_word;
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         clr_cnt_ff     <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         pos_z_ff       <= '0;
         done_ff        <= 1'b0;
         error_ff       <= 1'b0;
         size_x_ff      <= SIZE_RESET;
         size_y_ff      <= SIZE_RESET;
         size_z_ff      <= SIZE_RESET;
         label_count_ff <= LCOUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         pos_z_ff     <= pos_z_in;
         done_ff      <= done_in;
         error_ff     <= error_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CFG_SIZE_X:      size_x_ff      <= csr_data[SIZE_W-1:0];
               CFG_SIZE_Y:      size_y_ff      <= csr_data[SIZE_W-1:0];
               CFG_SIZE_Z:      size_z_ff      <= csr_data[SIZE_W-1:0];
               CFG_LABEL_COUNT: label_count_ff <= csr_data[LCOUNT_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_op;
         s1_label_ff <= req_label;
         fwd_data_ff <= mem_wr_data;
      end
      if (s1_fire) begin
         rsp_status_ff <= res_status;
         for (int k = 0; k < 3; k++) begin
            rsp_min_ff[k] <= res_min[k];
            rsp_max_ff[k] <= res_max[k];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_min_x  = rsp_min_ff[0];
   assign rsp_min_y  = rsp_min_ff[1];
   assign rsp_min_z  = rsp_min_ff[2];
   assign rsp_max_x  = rsp_max_ff[0];
   assign rsp_max_y  = rsp_max_ff[1];
   assign rsp_max_z  = rsp_max_ff[2];

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `ASSERT_IMPLY(a_no_work_in_sweep, clock, reset, state_ff == ST_SWEEP, !s1_valid_ff, "request in execute stage during table sweep")
   `ASSERT_NEXT(a_clear_starts_sweep, clock, reset, s1_fire && (s1_op_ff == OP_CLEAR), state_ff == ST_SWEEP, "clear request did not start a sweep")
   `ASSERT_NEXT(a_invalid_sets_error, clock, reset, s1_fire && (res_status == STAT_INVALID), error_ff, "invalid label did not set the error flag")
   `ASSERT_IMPLY(a_sweep_from_zero, clock, reset, $rose(state_ff == ST_SWEEP), clr_cnt_ff == '0, "sweep did not start at entry zero")

endmodule
